@@ sv/ppm_pkg.sv @@
package ppm_pkg;

  // Field widths
  localparam int unsigned SampleW = 24;
  localparam int unsigned ChW     = 3;
  localparam int unsigned LevelW  = 23;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned CfgIdxW = 1;

  // Channel number widened so it can be compared against channel counts below 128
  localparam int unsigned ChExtW = 7;

  // Default channel count
  localparam int unsigned NumChannelsDef = 8;

  // Unity in Q0.24, one bit wider than a coefficient
  localparam logic [CoefW:0] OneQ24 = 25'h100_0000;

  // Coefficient reset values
  localparam logic [CoefW-1:0] AttackReset  = 24'd76719;
  localparam logic [CoefW-1:0] ReleaseReset = 24'd513;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegAttack  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRelease = 1'b1;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_value;
    logic [ChW-1:0]            channel;
    logic                      block_end;
  } in_item_t;

  typedef struct packed {
    logic [ChW-1:0]    out_channel;
    logic [LevelW-1:0] peak_level;
  } out_item_t;

endpackage

@@ sv/peak_program_meter_core.sv @@
// Multichannel peak program meter.
// Input channel: in_valid_i / in_stall_o carry one sample transaction
// (sample_value, channel, block_end). Samples for channels at or above
// NUM_CHANNELS are taken and dropped without effect.
// Output channel: out_valid_o / out_stall_i carry one transaction per
// sample marked block_end: the channel and the highest meter level seen
// since that channel's previous block end.
// Configuration: cfg_we_i writes attack (index 0) or release (index 1)
// coefficient, unsigned Q0.24; write only while the block is idle.
// Each sample passes stage one and stage two; a block end then fills the output register.
// Throughput: one sample per cycle while out_stall_i holds no result. A sample for
// the same channel as the sample directly ahead of it waits in stage one, since the
// per-channel level feeds back through the multiply stage and the add stage.
// State sits in one RAM word per channel (level and block maximum) with a
// registered read port; a write-back register forwards the latest write.
// Reset: coefficients return to their defaults and per-channel valid flags
// clear, so every level and maximum reads as zero. No clearing pass.
// A held result stops block ends in stage two; the pipeline fills, in_stall_o rises.
module peak_program_meter_core #(
  parameter int unsigned NUM_CHANNELS = ppm_pkg::NumChannelsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ppm_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ppm_pkg::out_item_t          out_data_o,
  input  logic                        cfg_we_i,
  input  logic [ppm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ppm_pkg::CoefW-1:0]   cfg_data_i
);

  import ppm_pkg::*;

  localparam int unsigned IdxW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned WordW = 2 * LevelW;

  // Configuration registers
  logic [CoefW-1:0] attack_q, release_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= AttackReset;
      release_q <= ReleaseReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegAttack:  attack_q  <= cfg_data_i;
        RegRelease: release_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input side: magnitude with saturation, channel range check
  logic               in_accept, in_range;
  logic [ChExtW-1:0]  ch_ext;
  logic [IdxW-1:0]    in_idx;
  logic [SampleW-1:0] raw, abs_val;
  logic [LevelW-1:0]  in_mag;

  assign in_accept = in_valid_i && !in_stall_o;
  assign ch_ext    = {{(ChExtW - ChW){1'b0}}, in_data_i.channel};
  assign in_range  = ch_ext < ChExtW'(NUM_CHANNELS);
  assign in_idx    = ch_ext[IdxW-1:0];
  assign raw       = in_data_i.sample_value;
  assign abs_val   = raw[SampleW-1] ? (~raw + 1'b1) : raw;
  assign in_mag    = abs_val[SampleW-1] ? {LevelW{1'b1}} : abs_val[LevelW-1:0];

  // Pipeline control
  logic              s1_valid_q, s2_valid_q, out_valid_q;
  logic [IdxW-1:0]   s1_idx_q, s2_idx_q;
  logic [ChW-1:0]    s1_ch_q, s2_ch_q;
  logic              s1_last_q, s2_last_q;
  logic [LevelW-1:0] s1_mag_q;
  logic              s1_rvalid_q;
  logic [LevelW-1:0] s2_bmax_q;
  logic              hazard, s1_go, s2_go, s2_free, out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_go      = s2_valid_q && (!s2_last_q || out_free);
  assign s2_free    = !s2_valid_q || s2_go;
  assign hazard     = s1_valid_q && s2_valid_q && (s1_idx_q == s2_idx_q);
  assign s1_go      = s1_valid_q && s2_free && !hazard;
  assign in_stall_o = s1_valid_q && !s1_go;

  // Per-entry valid flags: an entry never written reads as zero
  logic [NUM_CHANNELS-1:0] ent_valid_q;

  // Write-back register: the latest RAM write, forwarded to stage one
  logic              wb_valid_q;
  logic [IdxW-1:0]   wb_idx_q;
  logic [LevelW-1:0] wb_level_q, wb_bmax_q;

  // State RAM: {block maximum, level} per channel
  logic [WordW-1:0]  mem_rdata, mem_wdata;
  logic [LevelW-1:0] s2_next, s2_max, s2_bmax_new;

  assign s2_max      = (s2_next > s2_bmax_q) ? s2_next : s2_bmax_q;
  assign s2_bmax_new = s2_last_q ? '0 : s2_max;
  assign mem_wdata   = {s2_bmax_new, s2_next};

  ppm_ram #(
    .Depth (NUM_CHANNELS),
    .AddrW (IdxW),
    .DataW (WordW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (s2_go),
    .waddr_i (s2_idx_q),
    .wdata_i (mem_wdata),
    .re_i    (in_accept),
    .raddr_i (in_idx),
    .rdata_o (mem_rdata)
  );

  // Stage one operands: forwarded write, else RAM data, else zero
  logic [LevelW-1:0] s1_level, s1_bmax;

  always_comb begin
    if (wb_valid_q && (wb_idx_q == s1_idx_q)) begin
      s1_level = wb_level_q;
      s1_bmax  = wb_bmax_q;
    end else if (s1_rvalid_q) begin
      s1_level = mem_rdata[LevelW-1:0];
      s1_bmax  = mem_rdata[WordW-1:LevelW];
    end else begin
      s1_level = '0;
      s1_bmax  = '0;
    end
  end

  ppm_calc u_calc (
    .clk_i           (clk_i),
    .en_i            (s1_go),
    .level_i         (s1_level),
    .mag_i           (s1_mag_q),
    .attack_coeff_i  (attack_q),
    .release_coeff_i (release_q),
    .next_level_o    (s2_next)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wb_valid_q  <= 1'b0;
      ent_valid_q <= '0;
    end else begin
      if (s1_go || !s1_valid_q) begin
        s1_valid_q <= in_accept && in_range;
      end
      if (s2_free) begin
        s2_valid_q <= s1_go;
      end
      if (s2_go && s2_last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (s2_go) begin
        wb_valid_q            <= 1'b1;
        ent_valid_q[s2_idx_q] <= 1'b1;
      end
    end
  end

  // Payload registers
  out_item_t out_data_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_idx_q    <= in_idx;
      s1_ch_q     <= in_data_i.channel;
      s1_last_q   <= in_data_i.block_end;
      s1_mag_q    <= in_mag;
      s1_rvalid_q <= ent_valid_q[in_idx];
    end
    if (s1_go) begin
      s2_idx_q  <= s1_idx_q;
      s2_ch_q   <= s1_ch_q;
      s2_last_q <= s1_last_q;
      s2_bmax_q <= s1_bmax;
    end
    if (s2_go) begin
      wb_idx_q   <= s2_idx_q;
      wb_level_q <= s2_next;
      wb_bmax_q  <= s2_bmax_new;
    end
    if (s2_go && s2_last_q) begin
      out_data_q.out_channel <= s2_ch_q;
      out_data_q.peak_level  <= s2_max;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Block end produces a result carrying its channel
  a_block_end_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && s2_last_q) |=> (out_valid_o && out_data_o.out_channel == $past(s2_ch_q)))
    else $error("block end did not produce its result");

  // Block maximum is cleared in the forwarded state after a report
  a_max_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && s2_last_q) |=> (wb_bmax_q == '0))
    else $error("block maximum not cleared after report");

  // Same-channel overlap in the pipeline must hold off new input
  a_hazard_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && s1_idx_q == s2_idx_q) |-> in_stall_o)
    else $error("input taken during same-channel interlock");

endmodule

@@ sv/ppm_ram.sv @@
module ppm_ram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3,
  parameter int unsigned DataW = 46
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ppm_calc.sv @@
module ppm_calc (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ppm_pkg::LevelW-1:0]  level_i,
  input  logic [ppm_pkg::LevelW-1:0]  mag_i,
  input  logic [ppm_pkg::CoefW-1:0]   attack_coeff_i,
  input  logic [ppm_pkg::CoefW-1:0]   release_coeff_i,
  output logic [ppm_pkg::LevelW-1:0]  next_level_o
);

  import ppm_pkg::*;

  localparam int unsigned P1W  = CoefW + LevelW;
  localparam int unsigned P2W  = CoefW + 1 + LevelW;
  localparam int unsigned SumW = P2W + 1;

  logic               attack;
  logic [CoefW-1:0]   c_mag;
  logic [CoefW:0]     c_level;
  logic [P1W-1:0]     p_mag_d, p_mag_q;
  logic [P2W-1:0]     p_level_d, p_level_q;
  logic [SumW-1:0]    sum;

  // Coefficient select: release only scales the level, attack blends
  assign attack  = !(level_i > mag_i);
  assign c_mag   = attack ? attack_coeff_i : '0;
  assign c_level = attack ? (OneQ24 - {1'b0, attack_coeff_i})
                          : (OneQ24 - {1'b0, release_coeff_i});

  assign p_mag_d   = {{LevelW{1'b0}}, c_mag} * {{CoefW{1'b0}}, mag_i};
  assign p_level_d = {{LevelW{1'b0}}, c_level} * {{(CoefW + 1){1'b0}}, level_i};

  // Product registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_mag_q   <= p_mag_d;
      p_level_q <= p_level_d;
    end
  end

  // Exact sum, truncated once
  assign sum          = {2'b00, p_mag_q} + {1'b0, p_level_q};
  assign next_level_o = sum[CoefW +: LevelW];

endmodule
